@@ rtl/gdgf_pkg.sv @@
// Shared types, constants and register indexes of the decap gap fill unit.
package gdgf_pkg;

    localparam int TYPE_SLOTS = 4;
    localparam int MAX_CELLS  = 64;

    localparam int SPAN_W  = 26;
    localparam int CAP_W   = 32;
    localparam int TOT_W   = 48;
    localparam int PAD_W   = 16;
    localparam int X_W     = 32;
    localparam int CNT_W   = 32;
    localparam int WORD_W  = 58;
    localparam int TCNT_W  = 3;
    localparam int IDX_W   = 2;
    localparam int N_W     = $clog2(MAX_CELLS + 1);
    localparam int WACC_W  = SPAN_W + N_W;
    localparam int CACC_W  = CAP_W + N_W;
    localparam int AVW_W   = SPAN_W + 1;
    localparam int AVC_W   = TOT_W + 1;
    localparam int ALU_W   = TOT_W + 2;
    localparam int CFG_A_W = 3;

    localparam logic [TOT_W-1:0] CAP_MAX = {TOT_W{1'b1}};

    localparam logic [CFG_A_W-1:0] CFG_TYPE_COUNT  = 3'd0;
    localparam logic [CFG_A_W-1:0] CFG_PAD_SPACE   = 3'd1;
    localparam logic [CFG_A_W-1:0] CFG_TARGET_CAP  = 3'd2;
    localparam logic [CFG_A_W-1:0] CFG_TYPE_WORD_0 = 3'd3;
    localparam logic [CFG_A_W-1:0] CFG_TYPE_WORD_1 = 3'd4;
    localparam logic [CFG_A_W-1:0] CFG_TYPE_WORD_2 = 3'd5;
    localparam logic [CFG_A_W-1:0] CFG_TYPE_WORD_3 = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_LOAD,
        S_TESTW,
        S_TESTC,
        S_PLACE,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [TCNT_W-1:0]                  type_count;
        logic [PAD_W-1:0]                   pad_space;
        logic [CAP_W-1:0]                   target_cap;
        logic [TYPE_SLOTS-1:0][WORD_W-1:0]  type_word;
    } t_cfg;

    typedef struct packed {
        logic                    placed;
        logic [IDX_W-1:0]        type_index;
        logic signed [X_W-1:0]   cell_left;
        logic [CNT_W-1:0]        serial;
        logic                    capped;
        logic                    last;
    } t_result;

endpackage

@@ rtl/gdgf_if.sv @@
// Handshake channel interfaces for gap requests and placed-cell results.
interface gdgf_gap_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   action;
    logic signed [gdgf_pkg::X_W-1:0]        gap_left;
    logic [gdgf_pkg::SPAN_W-1:0]            gap_span;

    modport source (output valid, action, gap_left, gap_span, input ready);
    modport sink (input valid, action, gap_left, gap_span, output ready);
endinterface

interface gdgf_cell_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   placed;
    logic [gdgf_pkg::IDX_W-1:0]             type_index;
    logic signed [gdgf_pkg::X_W-1:0]        cell_left;
    logic [gdgf_pkg::CNT_W-1:0]             serial;
    logic                                   capped;
    logic                                   last;

    modport source (output valid, placed, type_index, cell_left, serial, capped, last,
                    input ready);
    modport sink (input valid, placed, type_index, cell_left, serial, capped, last,
                  output ready);
endinterface

@@ rtl/gdgf_alu.sv @@
// Shared signed adder with a compare against a limit.
module gdgf_alu (
    input  logic signed [gdgf_pkg::ALU_W-1:0] i_a,
    input  logic signed [gdgf_pkg::ALU_W-1:0] i_b,
    input  logic signed [gdgf_pkg::ALU_W-1:0] i_lim,
    output logic signed [gdgf_pkg::ALU_W-1:0] o_sum,
    output logic                              o_le
);

    assign o_sum = i_a + i_b;
    assign o_le  = (o_sum <= i_lim);

endmodule

@@ rtl/gdgf_ctrl.sv @@
// Sequencer and datapath that walk the cell-type table for one gap.
module gdgf_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gdgf_pkg::t_cfg                      i_cfg,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_action,
    input  logic signed [gdgf_pkg::X_W-1:0]     i_gap_left,
    input  logic [gdgf_pkg::SPAN_W-1:0]         i_gap_span,
    input  logic                                i_push_ok,
    output logic                                o_push,
    output gdgf_pkg::t_result                   o_result
);

    gdgf_pkg::t_state                         r_state;
    gdgf_pkg::t_state                         n_state;
    logic [gdgf_pkg::TCNT_W-1:0]              r_t;
    logic [gdgf_pkg::N_W-1:0]                 r_n;
    logic [gdgf_pkg::N_W-1:0]                 n_n;
    logic [gdgf_pkg::X_W-1:0]                 r_x;
    logic [gdgf_pkg::SPAN_W-1:0]              r_span;
    logic signed [gdgf_pkg::AVW_W-1:0]        r_avail_w;
    logic signed [gdgf_pkg::AVC_W-1:0]        r_avail_c;
    logic [gdgf_pkg::WACC_W-1:0]              r_w_acc;
    logic [gdgf_pkg::CACC_W-1:0]              r_c_acc;
    logic [gdgf_pkg::WACC_W-1:0]              r_sum_w;
    logic [gdgf_pkg::CACC_W-1:0]              r_sum_c;
    logic [gdgf_pkg::SPAN_W-1:0]              r_w;
    logic [gdgf_pkg::CAP_W-1:0]               r_c;
    logic                                     r_pend_valid;
    gdgf_pkg::t_result                        r_pend;
    logic [gdgf_pkg::TOT_W-1:0]               r_cap_total;
    logic [gdgf_pkg::CNT_W-1:0]               r_cell_count;

    logic [gdgf_pkg::TCNT_W-1:0]              n_types;
    logic                                     fire;
    logic                                     place_go;
    logic                                     exact;
    logic                                     at_limit;
    logic [gdgf_pkg::WORD_W-1:0]              type_word;
    gdgf_pkg::t_result                        empty_last;

    logic signed [gdgf_pkg::ALU_W-1:0]        alu_a;
    logic signed [gdgf_pkg::ALU_W-1:0]        alu_b;
    logic signed [gdgf_pkg::ALU_W-1:0]        alu_lim;
    logic signed [gdgf_pkg::ALU_W-1:0]        alu_sum;
    logic                                     alu_le;

    gdgf_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_lim (alu_lim),
        .o_sum (alu_sum),
        .o_le  (alu_le)
    );

    assign n_types = (i_cfg.type_count > gdgf_pkg::TCNT_W'(gdgf_pkg::TYPE_SLOTS))
                   ? gdgf_pkg::TCNT_W'(gdgf_pkg::TYPE_SLOTS) : i_cfg.type_count;
    assign fire      = i_in_valid && o_in_ready;
    assign place_go  = !r_pend_valid || i_push_ok;
    assign n_n       = r_n + 1'b1;
    assign exact     = (r_sum_w == gdgf_pkg::WACC_W'(r_span));
    assign at_limit  = (n_n == gdgf_pkg::N_W'(gdgf_pkg::MAX_CELLS));
    assign type_word = i_cfg.type_word[r_t[gdgf_pkg::IDX_W-1:0]];

    always_comb begin
        empty_last      = '0;
        empty_last.last = 1'b1;
    end

    always_comb begin
        unique case (r_state)
            gdgf_pkg::S_TESTW: begin
                alu_a   = gdgf_pkg::ALU_W'(r_w_acc);
                alu_b   = gdgf_pkg::ALU_W'(r_w);
                alu_lim = gdgf_pkg::ALU_W'(r_avail_w);
            end
            gdgf_pkg::S_TESTC: begin
                alu_a   = gdgf_pkg::ALU_W'(r_c_acc);
                alu_b   = gdgf_pkg::ALU_W'(r_c);
                alu_lim = gdgf_pkg::ALU_W'(r_avail_c);
            end
            default: begin
                alu_a   = gdgf_pkg::ALU_W'(r_cap_total);
                alu_b   = gdgf_pkg::ALU_W'(r_c);
                alu_lim = gdgf_pkg::ALU_W'(gdgf_pkg::CAP_MAX);
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gdgf_pkg::S_IDLE: begin
                if (fire) begin
                    n_state = i_action ? gdgf_pkg::S_CLEAR : gdgf_pkg::S_LOAD;
                end
            end
            gdgf_pkg::S_CLEAR: begin
                if (i_push_ok) begin
                    n_state = gdgf_pkg::S_IDLE;
                end
            end
            gdgf_pkg::S_LOAD: begin
                n_state = (r_t >= n_types) ? gdgf_pkg::S_FIN : gdgf_pkg::S_TESTW;
            end
            gdgf_pkg::S_TESTW: begin
                n_state = alu_le ? gdgf_pkg::S_TESTC : gdgf_pkg::S_LOAD;
            end
            gdgf_pkg::S_TESTC: begin
                n_state = alu_le ? gdgf_pkg::S_PLACE : gdgf_pkg::S_LOAD;
            end
            gdgf_pkg::S_PLACE: begin
                if (place_go) begin
                    n_state = (exact || at_limit) ? gdgf_pkg::S_FIN : gdgf_pkg::S_TESTW;
                end
            end
            gdgf_pkg::S_FIN: begin
                if (i_push_ok) begin
                    n_state = gdgf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gdgf_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_push     = 1'b0;
        o_result   = empty_last;
        unique case (r_state)
            gdgf_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
            end
            gdgf_pkg::S_CLEAR: begin
                o_push = i_push_ok;
            end
            gdgf_pkg::S_PLACE: begin
                o_push   = r_pend_valid && i_push_ok;
                o_result = r_pend;
            end
            gdgf_pkg::S_FIN: begin
                o_push = i_push_ok;
                if (r_pend_valid) begin
                    o_result      = r_pend;
                    o_result.last = 1'b1;
                end
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= gdgf_pkg::S_IDLE;
            r_pend_valid <= 1'b0;
            r_cap_total  <= '0;
            r_cell_count <= '0;
            r_t          <= '0;
            r_n          <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                gdgf_pkg::S_IDLE: begin
                    if (fire) begin
                        r_t          <= '0;
                        r_n          <= '0;
                        r_pend_valid <= 1'b0;
                        r_x          <= i_gap_left;
                        r_span       <= i_gap_span;
                        r_w_acc      <= '0;
                        r_c_acc      <= '0;
                        r_avail_w    <= $signed({1'b0, i_gap_span})
                                      - $signed(gdgf_pkg::AVW_W'(i_cfg.pad_space));
                        r_avail_c    <= $signed(gdgf_pkg::AVC_W'(i_cfg.target_cap))
                                      - $signed({1'b0, r_cap_total});
                        if (i_action) begin
                            r_cap_total  <= '0;
                            r_cell_count <= '0;
                        end
                    end
                end
                gdgf_pkg::S_LOAD: begin
                    r_w <= type_word[gdgf_pkg::SPAN_W-1:0];
                    r_c <= type_word[gdgf_pkg::WORD_W-1:gdgf_pkg::SPAN_W];
                end
                gdgf_pkg::S_TESTW: begin
                    r_sum_w <= alu_sum[gdgf_pkg::WACC_W-1:0];
                    if (!alu_le) begin
                        r_t <= r_t + 1'b1;
                    end
                end
                gdgf_pkg::S_TESTC: begin
                    r_sum_c <= alu_sum[gdgf_pkg::CACC_W-1:0];
                    if (!alu_le) begin
                        r_t <= r_t + 1'b1;
                    end
                end
                gdgf_pkg::S_PLACE: begin
                    if (place_go) begin
                        r_pend_valid      <= 1'b1;
                        r_pend.placed     <= 1'b1;
                        r_pend.type_index <= r_t[gdgf_pkg::IDX_W-1:0];
                        r_pend.cell_left  <= r_x;
                        r_pend.serial     <= r_cell_count;
                        r_pend.capped     <= at_limit && !exact;
                        r_pend.last       <= 1'b0;
                        r_x               <= r_x + gdgf_pkg::X_W'(r_w);
                        r_w_acc           <= r_sum_w;
                        r_c_acc           <= r_sum_c;
                        r_n               <= n_n;
                        r_cell_count      <= r_cell_count + 1'b1;
                        r_cap_total       <= alu_le ? alu_sum[gdgf_pkg::TOT_W-1:0]
                                                    : gdgf_pkg::CAP_MAX;
                    end
                end
                gdgf_pkg::S_FIN: begin
                    if (i_push_ok) begin
                        r_pend_valid <= 1'b0;
                    end
                end
                default: begin
                    r_pend_valid <= r_pend_valid;
                end
            endcase
        end
    end

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_push_ok)
        else $error("result pushed while the output register is full");

    a_cell_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= gdgf_pkg::N_W'(gdgf_pkg::MAX_CELLS))
        else $error("cell count per gap beyond limit");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> !o_in_ready)
        else $error("ready again right after a transfer");

    a_pending_in_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gdgf_pkg::S_PLACE && place_go) |=> r_pend_valid && r_pend.placed)
        else $error("placed cell not held as pending result");

endmodule

@@ rtl/greedy_decap_gap_fill_unit.sv @@
// Top level of the greedy decap gap fill unit with configuration and output register.
//
// Gap requests arrive on i_gap (valid/ready); each transfer carries action, gap_left
// and gap_span. Results leave on o_cell, one transfer per placed cell, with last set
// on the final result of a request; a fill that places no cell returns one empty
// result with last set. A clear request (action 1) zeroes the running capacitance
// total and cell count and returns one empty result with last set.
// Configuration registers are written through i_cfg_we, i_cfg_index and i_cfg_data
// while no request is in progress: a rule for the user that the block does not enforce.
// One request is processed at a time under a small sequencer that drives a single
// shared adder and comparator. Each placed cell passes a width test, a capacitance
// test and a placement step; each type tried is loaded and tested until a test fails
// and the walk moves to the next type. A walk ends early on an exact fill or at the
// cell limit. A result waits in the output register until o_cell.ready is high;
// while it waits the sequencer holds any further result of the request, and i_gap
// stays not ready until the last result of the request is in the output register.
// Reset clears the configuration, the running total, the cell count and all
// handshake state; the block is ready in the first cycle after reset.
module greedy_decap_gap_fill_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gdgf_pkg::CFG_A_W-1:0]        i_cfg_index,
    input  logic [gdgf_pkg::WORD_W-1:0]         i_cfg_data,
    gdgf_gap_if.sink                            i_gap,
    gdgf_cell_if.source                         o_cell
);

    gdgf_pkg::t_cfg     r_cfg;
    logic               r_out_valid;
    gdgf_pkg::t_result  r_out;
    logic               push_ok;
    logic               push;
    gdgf_pkg::t_result  result;
    logic               in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gdgf_pkg::CFG_TYPE_COUNT: begin
                    r_cfg.type_count <= i_cfg_data[gdgf_pkg::TCNT_W-1:0];
                end
                gdgf_pkg::CFG_PAD_SPACE: begin
                    r_cfg.pad_space <= i_cfg_data[gdgf_pkg::PAD_W-1:0];
                end
                gdgf_pkg::CFG_TARGET_CAP: begin
                    r_cfg.target_cap <= i_cfg_data[gdgf_pkg::CAP_W-1:0];
                end
                gdgf_pkg::CFG_TYPE_WORD_0: begin
                    r_cfg.type_word[0] <= i_cfg_data;
                end
                gdgf_pkg::CFG_TYPE_WORD_1: begin
                    r_cfg.type_word[1] <= i_cfg_data;
                end
                gdgf_pkg::CFG_TYPE_WORD_2: begin
                    r_cfg.type_word[2] <= i_cfg_data;
                end
                gdgf_pkg::CFG_TYPE_WORD_3: begin
                    r_cfg.type_word[3] <= i_cfg_data;
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign push_ok = !r_out_valid || o_cell.ready;

    gdgf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_gap.valid),
        .o_in_ready (in_ready),
        .i_action   (i_gap.action),
        .i_gap_left (i_gap.gap_left),
        .i_gap_span (i_gap.gap_span),
        .i_push_ok  (push_ok),
        .o_push     (push),
        .o_result   (result)
    );

    assign i_gap.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push_ok) begin
            r_out_valid <= push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && push_ok) begin
            r_out <= result;
        end
    end

    assign o_cell.valid      = r_out_valid;
    assign o_cell.placed     = r_out.placed;
    assign o_cell.type_index = r_out.type_index;
    assign o_cell.cell_left  = r_out.cell_left;
    assign o_cell.serial     = r_out.serial;
    assign o_cell.capped     = r_out.capped;
    assign o_cell.last       = r_out.last;

endmodule

@@ tb/tb_greedy_decap_gap_fill_unit.sv @@
// Self-checking testbench for the greedy decap gap fill unit with a gap walk predictor.
`timescale 1ns / 100ps

module tb_greedy_decap_gap_fill_unit;
    import gdgf_pkg::*;

    localparam int LIMIT_CYCLES       = 2_000_000;
    localparam int SETTLE_CYCLES      = 16;
    localparam int SETTINGS_PER_PHASE = 4;
    localparam int GAPS_PER_SETTING   = 42;

    localparam logic ACT_FILL  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    localparam logic [SPAN_W-1:0] SPAN_MAX = {SPAN_W{1'b1}};

    class gap_fill_scoreboard;
        t_cfg             regs;
        logic [TOT_W-1:0] cap_total;
        logic [CNT_W-1:0] cell_count;
        t_result          pending_cells[$];
        int               errors;
        int               gaps;
        int               clears;
        int               placed_cells;
        int               empty_results;
        int               capped_walks;
        int               exact_fills;

        function new();
            regs          = '0;
            cap_total     = '0;
            cell_count    = '0;
            errors        = 0;
            gaps          = 0;
            clears        = 0;
            placed_cells  = 0;
            empty_results = 0;
            capped_walks  = 0;
            exact_fills   = 0;
        endfunction

        function void set_register(logic [CFG_A_W-1:0] index, logic [WORD_W-1:0] data);
            unique case (index)
                CFG_TYPE_COUNT: begin
                    regs.type_count = data[TCNT_W-1:0];
                end
                CFG_PAD_SPACE: begin
                    regs.pad_space = data[PAD_W-1:0];
                end
                CFG_TARGET_CAP: begin
                    regs.target_cap = data[CAP_W-1:0];
                end
                CFG_TYPE_WORD_0, CFG_TYPE_WORD_1, CFG_TYPE_WORD_2, CFG_TYPE_WORD_3: begin
                    regs.type_word[IDX_W'(index - CFG_TYPE_WORD_0)] = data;
                end
                default: begin
                end
            endcase
        endfunction

        // Greedy type-table walk for an accepted fill; a clear expects one empty result.
        function void note_gap(logic action, logic [X_W-1:0] gap_left,
                               logic [SPAN_W-1:0] gap_span);
            t_result        walk[$];
            t_result        res;
            longint         avail_w;
            longint         avail_c;
            longint         w_acc;
            longint         c_acc;
            longint         width;
            longint         cap;
            longint         total;
            longint         pad;
            longint         span;
            logic [X_W-1:0] x;
            int             n_types;
            bit             done;

            gaps++;
            if (action == ACT_CLEAR) begin
                cap_total  = '0;
                cell_count = '0;
                clears++;
                res      = '0;
                res.last = 1'b1;
                pending_cells.insert(pending_cells.size(), res);
                return;
            end

            span    = gap_span;
            pad     = regs.pad_space;
            total   = cap_total;
            avail_w = span - pad;
            avail_c = regs.target_cap;
            avail_c = avail_c - total;
            w_acc   = 0;
            c_acc   = 0;
            x       = gap_left;
            done    = 1'b0;
            n_types = (regs.type_count > TYPE_SLOTS) ? TYPE_SLOTS : int'(regs.type_count);

            for (int t = 0; t < n_types && !done; t++) begin
                width = regs.type_word[t][SPAN_W-1:0];
                cap   = regs.type_word[t][WORD_W-1:SPAN_W];
                while (!done && w_acc + width <= avail_w && c_acc + cap <= avail_c) begin
                    res            = '0;
                    res.placed     = 1'b1;
                    res.type_index = t[IDX_W-1:0];
                    res.cell_left  = x;
                    res.serial     = cell_count;
                    x              = x + width[X_W-1:0];
                    w_acc          = w_acc + width;
                    c_acc          = c_acc + cap;
                    total          = cap_total;
                    total          = total + cap;
                    cap_total      = (total > CAP_MAX) ? CAP_MAX : total[TOT_W-1:0];
                    cell_count     = cell_count + 1'b1;
                    if (w_acc == span) begin
                        done = 1'b1;
                        exact_fills++;
                    end else if (walk.size() + 1 >= MAX_CELLS) begin
                        res.capped = 1'b1;
                        done       = 1'b1;
                        capped_walks++;
                    end
                    walk.insert(walk.size(), res);
                end
            end

            if (walk.size() == 0) begin
                res      = '0;
                res.last = 1'b1;
                walk.insert(walk.size(), res);
                empty_results++;
            end else begin
                walk[walk.size() - 1].last = 1'b1;
                placed_cells += walk.size();
            end
            foreach (walk[i]) pending_cells.insert(pending_cells.size(), walk[i]);
        endfunction

        function void compare_field(string field, longint want, longint got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_cell(t_result got);
            t_result want;
            if (pending_cells.size() == 0) begin
                $error("unexpected result transfer: placed %0d type_index %0d cell_left %0d",
                       got.placed, got.type_index, got.cell_left);
                errors++;
                return;
            end
            want = pending_cells.pop_front();
            compare_field("placed", want.placed, got.placed);
            compare_field("type_index", want.type_index, got.type_index);
            compare_field("cell_left", want.cell_left, got.cell_left);
            compare_field("serial", want.serial, got.serial);
            compare_field("capped", want.capped, got.capped);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_A_W-1:0] i_cfg_index;
    logic [WORD_W-1:0]  i_cfg_data;

    gdgf_gap_if  gap_ch ();
    gdgf_cell_if cell_ch ();

    gap_fill_scoreboard sb = new();

    int send_idle      = 11;
    int recv_idle      = 76;
    int cycles         = 0;
    int settings_used  = 0;

    greedy_decap_gap_fill_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_gap       (gap_ch),
        .o_cell      (cell_ch)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("tb_greedy_decap_gap_fill_unit failed");
            $finish;
        end
    end

    initial begin
        cell_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (cell_ch.valid === 1'b1 && cell_ch.ready) begin
                sb.check_cell({cell_ch.placed, cell_ch.type_index, cell_ch.cell_left,
                               cell_ch.serial, cell_ch.capped, cell_ch.last});
            end
            cell_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    task automatic write_register(logic [CFG_A_W-1:0] index, logic [WORD_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_register(index, data);
    endtask

    task automatic load_setting(t_cfg c);
        write_register(CFG_TYPE_COUNT, WORD_W'(c.type_count));
        write_register(CFG_PAD_SPACE, WORD_W'(c.pad_space));
        write_register(CFG_TARGET_CAP, WORD_W'(c.target_cap));
        for (int i = 0; i < TYPE_SLOTS; i++) begin
            write_register(CFG_A_W'(CFG_TYPE_WORD_0 + i), c.type_word[i]);
        end
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic send_gap(logic action, logic [X_W-1:0] gap_left,
                            logic [SPAN_W-1:0] gap_span);
        while ($urandom_range(0, 99) < send_idle) begin
            gap_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        gap_ch.valid    <= 1'b1;
        gap_ch.action   <= action;
        gap_ch.gap_left <= gap_left;
        gap_ch.gap_span <= gap_span;
        @(posedge i_clk);
        while (!gap_ch.ready) @(posedge i_clk);
        sb.note_gap(action, gap_left, gap_span);
    endtask

    task automatic wait_drained();
        gap_ch.valid <= 1'b0;
        while (sb.pending_cells.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_cfg make_setting();
        t_cfg              c;
        logic [CAP_W-1:0]  caps [TYPE_SLOTS];
        logic [CAP_W-1:0]  swap;
        logic [SPAN_W-1:0] width;
        int                roll;
        int                wscale;
        int                cscale;
        longint            budget;

        c    = '0;
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
            c.type_count = '0;
        end else if (roll < 16) begin
            c.type_count = TCNT_W'($urandom_range(TYPE_SLOTS + 1, 7));
        end else begin
            c.type_count = TCNT_W'($urandom_range(1, TYPE_SLOTS));
        end

        wscale = $urandom_range(0, 3);
        cscale = $urandom_range(0, 2);
        foreach (caps[i]) begin
            unique case (cscale)
                0:       caps[i] = CAP_W'($urandom_range(0, 32'hFFFF));
                1:       caps[i] = CAP_W'($urandom_range(32'h1_0000, 32'h8_0000));
                default: caps[i] = $urandom;
            endcase
        end
        // Software loads the table by falling capacitance; leave a few tables unsorted.
        if ($urandom_range(0, 9) != 0) begin
            for (int i = 0; i < TYPE_SLOTS - 1; i++) begin
                for (int j = 0; j < TYPE_SLOTS - 1 - i; j++) begin
                    if (caps[j] < caps[j + 1]) begin
                        swap        = caps[j];
                        caps[j]     = caps[j + 1];
                        caps[j + 1] = swap;
                    end
                end
            end
        end
        for (int i = 0; i < TYPE_SLOTS; i++) begin
            unique case (wscale)
                0:       width = SPAN_W'($urandom_range(1, 8));
                1:       width = SPAN_W'($urandom_range(1, 200));
                2:       width = SPAN_W'($urandom_range(0, 3));
                default: width = SPAN_W'($urandom);
            endcase
            c.type_word[i] = {caps[i], width};
        end

        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            c.pad_space = '0;
        end else if (roll < 90) begin
            c.pad_space = PAD_W'($urandom_range(1, 40));
        end else begin
            c.pad_space = PAD_W'($urandom);
        end

        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            c.target_cap = '0;
        end else if (roll < 16) begin
            c.target_cap = '1;
        end else if (roll < 26 || caps[0] == '0) begin
            c.target_cap = $urandom;
        end else begin
            budget = caps[0];
            budget = budget * $urandom_range(2, 300) + $urandom_range(0, 32'hFFFF);
            c.target_cap = (budget > 64'h0000_0000_FFFF_FFFF) ? '1 : budget[CAP_W-1:0];
        end
        return c;
    endfunction

    task automatic send_random_gap();
        logic           action;
        logic [X_W-1:0] gap_left;
        longint         span;
        longint         w0;
        longint         w1;
        longint         wmax;
        longint         pad;
        int             roll;

        action   = ($urandom_range(0, 99) < 7) ? ACT_CLEAR : ACT_FILL;
        gap_left = ($urandom_range(0, 9) == 0) ? X_W'(32'h7FFF_FF00 + $urandom_range(0, 255))
                                               : X_W'($urandom);
        w0   = sb.regs.type_word[0][SPAN_W-1:0];
        w1   = sb.regs.type_word[1][SPAN_W-1:0];
        pad  = sb.regs.pad_space;
        wmax = 0;
        for (int i = 0; i < TYPE_SLOTS; i++) begin
            if (sb.regs.type_word[i][SPAN_W-1:0] > wmax) begin
                wmax = sb.regs.type_word[i][SPAN_W-1:0];
            end
        end

        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            span = $urandom_range(0, SPAN_MAX);
        end else if (roll < 40) begin
            span = pad + w0 * $urandom_range(0, 6) + w1 * $urandom_range(0, 6);
        end else begin
            span = pad + wmax * $urandom_range(0, 12) + $urandom_range(0, 3);
        end
        if (span > SPAN_MAX) begin
            span = SPAN_MAX;
        end
        send_gap(action, gap_left, span[SPAN_W-1:0]);
    endtask

    task automatic run_directed();
        t_cfg c;

        send_gap(ACT_FILL, 32'h0000_0000, '0);
        send_gap(ACT_FILL, 32'h7FFF_FFFF, SPAN_MAX);

        wait_drained();
        c              = '0;
        c.type_count   = 3'd2;
        c.target_cap   = '1;
        c.type_word[0] = {32'h0003_0000, 26'd10};
        c.type_word[1] = {32'h0001_0000, 26'd3};
        load_setting(c);
        send_gap(ACT_FILL, 32'h7FFF_FFF0, 26'd26);
        send_gap(ACT_FILL, 32'hFFFF_FFFF, 26'd25);
        send_gap(ACT_FILL, 32'h0000_0064, 26'd5);
        send_gap(ACT_FILL, 32'h0000_0064, 26'd2);
        send_gap(ACT_FILL, 32'h8000_0000, SPAN_MAX);
        send_gap(ACT_CLEAR, 32'h5555_5555, 26'h2AA_AAAA);

        // Oversized type count, padding wider than small gaps, zero-size type at the end.
        wait_drained();
        c.type_count   = 3'd7;
        c.pad_space    = '1;
        c.target_cap   = 32'h0005_0000;
        c.type_word[0] = '1;
        c.type_word[1] = {32'h0002_0000, 26'd7};
        c.type_word[2] = {32'h0001_0000, 26'd1};
        c.type_word[3] = '0;
        load_setting(c);
        send_gap(ACT_FILL, 32'h0000_1000, 26'd100);
        send_gap(ACT_FILL, 32'h0000_0000, SPAN_MAX);
        send_gap(ACT_FILL, 32'hAAAA_AAAA, SPAN_MAX);

        wait_drained();
        c              = '0;
        c.type_count   = 3'd1;
        load_setting(c);
        send_gap(ACT_FILL, 32'h0000_0010, 26'd10);
        send_gap(ACT_CLEAR, 32'h0000_0000, '0);
        send_gap(ACT_FILL, 32'hDEAD_BEEF, '0);

        wait_drained();
        c.type_count   = 3'd4;
        c.target_cap   = '1;
        c.type_word[0] = '1;
        c.type_word[1] = {32'h0001_0000, 26'd4};
        c.type_word[2] = {32'h0000_0000, 26'd5};
        c.type_word[3] = '0;
        load_setting(c);
        send_gap(ACT_FILL, 32'h1234_5678, SPAN_MAX);
        send_gap(ACT_FILL, 32'h1234_5678, SPAN_MAX);
        send_gap(ACT_CLEAR, 32'hFFFF_FFFF, SPAN_MAX);

        wait_drained();
        c.type_count = '0;
        load_setting(c);
        send_gap(ACT_FILL, 32'h0000_0000, 26'd64);
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= CFG_TYPE_COUNT;
        i_cfg_data      <= '0;
        gap_ch.valid    <= 1'b0;
        gap_ch.action   <= ACT_FILL;
        gap_ch.gap_left <= '0;
        gap_ch.gap_span <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        for (int phase = 0; phase < 3; phase++) begin
            unique case (phase)
                0: begin
                    send_idle = 11;
                    recv_idle = 76;
                end
                1: begin
                    send_idle = 76;
                    recv_idle = 11;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
                wait_drained();
                load_setting(make_setting());
                repeat (GAPS_PER_SETTING) send_random_gap();
            end
        end
        wait_drained();

        $display("Covered %0d gap requests, %0d of them clears, under %0d register settings.",
                 sb.gaps, sb.clears, settings_used);
        $display("Saw %0d placed cells, %0d empty results, %0d walks at the cell limit, %0d exact fills.",
                 sb.placed_cells, sb.empty_results, sb.capped_walks, sb.exact_fills);
        if (sb.errors == 0) begin
            $display("tb_greedy_decap_gap_fill_unit passed");
        end else begin
            $display("tb_greedy_decap_gap_fill_unit failed");
        end
        $finish;
    end

endmodule
